// ===== rtl/core/tftp_read_session_table_defines.svh =====
// Assertion macros used by the session table controller.
// No dependencies.
`ifndef TFTP_READ_SESSION_TABLE_DEFINES_SVH
`define TFTP_READ_SESSION_TABLE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define TRST_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define TRST_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/core/trst_pkg.sv =====
// Package for the TFTP read session table: widths, opcodes, shared types.
// No dependencies.
package trst_pkg;
  localparam int NumSlots   = 128;
  localparam int SlotW      = $clog2(NumSlots);
  localparam int BlockBytes = 512;
  localparam int BlockShift = $clog2(BlockBytes);
  localparam logic [31:0] TimeoutReset = 32'd5000;

  localparam logic [1:0] OpRrq = 2'd0;
  localparam logic [1:0] OpAck = 2'd1;

  // Per-slot record held in the slot memory.
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] blk;
    logic        dropped;
    logic [31:0] last_used;
    logic [31:0] fsize;
  } slot_t;
  localparam int SlotBits = $bits(slot_t);

  // Datapath commands from the controller.
  typedef struct packed {
    logic          load_in;     // capture input item
    logic          scan_start;  // reset scan index
    logic          scan_step;   // advance scan index
    logic          rd_hit;      // read memory at hit slot
    logic          rd_alloc;    // read memory at round robin slot
    logic          set_hit;     // latch hit index from scan
    logic          wr_clear;    // clear addr/dropped of hit slot
    logic          wr_alloc;    // write new session into alloc slot
    logic          wr_reuse;    // write new session into hit slot
    logic          adv_ptr;     // advance round robin pointer
    logic          eval;        // evaluate the ack against the slot
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic          match;       // read data key matches current key
    logic          scan_last;   // read data index is last slot
    logic          timed_out;   // hit slot idle too long
    logic          is_rrq;
    logic          is_ack;
    logic          found;
    logic          serve;       // evaluation produced a result
  } stat_t;
endpackage

// ===== rtl/core/trst_if.sv =====
// Valid/ready channel interfaces for the session table.
// Depends on trst_pkg.
interface trst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] src_addr;
  logic [15:0] src_port;
  logic [15:0] ack_block;
  logic [31:0] now_ms;
  logic        file_found;
  logic [31:0] file_size;
  modport source(output valid, opcode, src_addr, src_port, ack_block, now_ms,
                 file_found, file_size, input ready);
  modport sink(input valid, opcode, src_addr, src_port, ack_block, now_ms,
               file_found, file_size, output ready);
endinterface

interface trst_out_if;
  logic        valid;
  logic        ready;
  logic [trst_pkg::SlotW-1:0] slot_index;
  logic [31:0] dst_addr;
  logic [15:0] dst_port;
  logic [15:0] data_block;
  logic [24:0] read_offset;
  logic [9:0]  payload_len;
  logic        is_final;
  modport source(output valid, slot_index, dst_addr, dst_port, data_block,
                 read_offset, payload_len, is_final, input ready);
  modport sink(input valid, slot_index, dst_addr, dst_port, data_block,
               read_offset, payload_len, is_final, output ready);
endinterface

// ===== rtl/core/trst_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module trst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/trst_datapath.sv =====
// Datapath: slot memory, valid bits, scan index, key compare, block math.
// Depends on trst_pkg, trst_ram, trst_if.
module trst_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  trst_pkg::cmd_t       cmd,
  output trst_pkg::stat_t      stat,
  trst_in_if.sink              in_ch,
  output logic [trst_pkg::SlotW-1:0] r_slot,
  output logic [31:0]          r_addr,
  output logic [15:0]          r_port,
  output logic [15:0]          r_block,
  output logic [24:0]          r_offset,
  output logic [9:0]           r_len,
  output logic                 r_final
);
  localparam int SW = trst_pkg::SlotW;

  logic [31:0] timeout;
  logic [1:0]  op;
  logic [31:0] key_addr, now, fsize;
  logic [15:0] key_port, ack, ack_eff;
  logic        found;
  logic [SW-1:0] scan_idx, hit_idx, alloc_ptr, mem_addr;
  logic [trst_pkg::NumSlots-1:0] vld;
  logic        rd_valid;
  logic [SW-1:0] rd_idx;
  trst_pkg::slot_t rdata, wdata, rd_eff;
  logic        we;

  always_ff @(posedge clk) begin
    if (rst) timeout <= trst_pkg::TimeoutReset;
    else if (cfg_we) timeout <= cfg_wdata;
  end

  // Capture the input item.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op <= in_ch.opcode; key_addr <= in_ch.src_addr; key_port <= in_ch.src_port;
      ack <= in_ch.ack_block; now <= in_ch.now_ms; found <= in_ch.file_found;
      fsize <= in_ch.file_size;
    end
  end

  // A read request is served as an acknowledgement of block 0.
  assign ack_eff = (op == trst_pkg::OpRrq) ? 16'd0 : ack;

  // Scan index, hit index and round robin pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_ptr <= '0;
      scan_idx <= '0;
    end else begin
      if (cmd.scan_start) scan_idx <= '0;
      else if (cmd.scan_step) scan_idx <= scan_idx + 1'b1;
      if (cmd.adv_ptr)
        alloc_ptr <= (alloc_ptr == SW'(trst_pkg::NumSlots - 1)) ? '0 : alloc_ptr + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.set_hit) hit_idx <= rd_idx;
    else if (cmd.wr_alloc) hit_idx <= alloc_ptr;
  end

  // Memory port: writes go to hit or alloc slot, reads to scan, hit or alloc slot.
  always_comb begin
    wdata = rd_eff;
    we = 1'b0;
    mem_addr = scan_idx;
    if (cmd.wr_clear) begin
      we = 1'b1; mem_addr = hit_idx;
      wdata.addr = '0; wdata.dropped = 1'b0;
    end else if (cmd.wr_alloc || cmd.wr_reuse) begin
      // Keep the last-used time of the target slot, read just before.
      we = 1'b1; mem_addr = cmd.wr_reuse ? hit_idx : alloc_ptr;
      wdata = '0;
      wdata.addr = key_addr; wdata.port = key_port; wdata.fsize = fsize;
      wdata.last_used = rd_eff.last_used;
    end else if (cmd.eval) begin
      we = 1'b1; mem_addr = hit_idx;
      wdata = rd_eff;
      if (rd_eff.blk != ack_eff && !rd_eff.dropped) wdata.dropped = 1'b1;
      else begin
        wdata.dropped = 1'b0;
        wdata.blk = (rd_eff.blk != ack_eff) ? ack_eff : rd_eff.blk;
        if (stat.serve) begin
          wdata.blk = ((rd_eff.blk != ack_eff) ? ack_eff : rd_eff.blk) + 16'd1;
          wdata.last_used = now;
        end
      end
    end else if (cmd.rd_hit) begin
      mem_addr = hit_idx;
    end else if (cmd.rd_alloc) begin
      mem_addr = alloc_ptr;
    end
  end

  trst_ram #(.Width(trst_pkg::SlotBits), .Depth(trst_pkg::NumSlots)) u_ram (
    .clk(clk), .we(we), .addr(mem_addr), .wdata(wdata), .rdata(rdata)
  );

  // Valid bits: an unwritten slot reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (we) vld[mem_addr] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    rd_idx <= mem_addr;
    rd_valid <= vld[mem_addr];
  end
  assign rd_eff = rd_valid ? rdata : '0;

  // Block arithmetic for the slot being evaluated.
  logic [15:0] eff_blk;
  logic [40:0] off;
  logic [40:0] rem;
  assign eff_blk = rd_eff.blk;
  always_comb begin
    logic [15:0] b;
    b = (rd_eff.blk != ack_eff) ? ack_eff : rd_eff.blk;
    off = {16'd0, b, 9'd0};
    rem = {9'd0, rd_eff.fsize} - off;
  end

  always_comb begin
    stat.match = (rd_eff.addr == key_addr) && (rd_eff.port == key_port);
    stat.scan_last = (rd_idx == SW'(trst_pkg::NumSlots - 1));
    stat.timed_out = (now - rd_eff.last_used) > timeout;
    stat.is_rrq = (op == trst_pkg::OpRrq);
    stat.is_ack = (op == trst_pkg::OpAck);
    stat.found = found;
    stat.serve = !((rd_eff.blk != ack_eff) && !rd_eff.dropped) &&
                 (off <= {9'd0, rd_eff.fsize});
  end

  // Register the result fields.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      r_slot <= hit_idx;
      r_addr <= key_addr;
      r_port <= key_port;
      r_block <= ((eff_blk != ack_eff) ? ack_eff : eff_blk) + 16'd1;
      r_offset <= off[24:0];
      r_len <= (rem > 41'd512) ? 10'd512 : rem[9:0];
      r_final <= !(rem >= 41'd512);
    end
  end
endmodule

// ===== rtl/core/trst_ctrl.sv =====
// Controller state machine sequencing the slot searches and writes.
// Depends on trst_pkg and the assertion macros header.
`include "tftp_read_session_table_defines.svh"
module trst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output trst_pkg::cmd_t  cmd,
  input  trst_pkg::stat_t stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_S1, S_S1W, S_TORD, S_TO, S_ALRD, S_ALLOC, S_S2, S_S2W, S_HITRD, S_HITW,
    S_EVAL, S_OUT
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  begin cmd.load_in = in_valid; cmd.scan_start = 1'b1; end
      S_S1, S_S2: cmd.scan_step = 1'b1;
      S_S1W, S_S2W: begin cmd.scan_step = !stat.match; cmd.set_hit = 1'b1; end
      S_TORD:  cmd.rd_hit = 1'b1;
      S_TO:    begin cmd.wr_clear = stat.timed_out;
                     cmd.wr_reuse = !stat.timed_out && stat.found;
                     cmd.scan_start = 1'b1; end
      S_ALRD:  cmd.rd_alloc = 1'b1;
      S_ALLOC: begin cmd.wr_alloc = stat.found; cmd.adv_ptr = 1'b1;
                     cmd.scan_start = 1'b1; end
      S_HITRD: cmd.rd_hit = 1'b1;
      S_HITW:  cmd.rd_hit = 1'b1;
      S_EVAL:  cmd.eval = 1'b1;
      S_OUT:   ;
      default: ;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_S1;
        S_S1: begin
          if (!(stat.is_rrq || stat.is_ack)) state <= S_IDLE;
          else if (stat.is_rrq) state <= S_S1W;
          else state <= S_S2W;
        end
        S_S1W: begin
          if (stat.match) state <= S_TORD;
          else if (stat.scan_last) state <= S_ALRD;
        end
        S_TORD: state <= S_TO;
        S_TO: begin
          if (stat.timed_out) state <= S_ALRD;
          else if (stat.found) state <= S_S2;
          else state <= S_IDLE;
        end
        S_ALRD:  state <= S_ALLOC;
        S_ALLOC: state <= stat.found ? S_S2 : S_IDLE;
        S_S2: state <= S_S2W;
        S_S2W: begin
          if (stat.match) state <= S_HITRD;
          else if (stat.scan_last) state <= S_IDLE;
        end
        S_HITRD: state <= S_HITW;
        S_HITW:  state <= S_EVAL;
        S_EVAL: begin
          if (stat.serve) begin state <= S_OUT; out_valid <= 1'b1; end
          else state <= S_IDLE;
        end
        S_OUT: if (out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TRST_ASSERT_IMP(a_ready_out, clk, rst, out_valid, !in_ready, "ready while result pending")
  `TRST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid,
                    "result dropped under stall")
  `TRST_ASSERT_IMP(a_eval_wr, clk, rst, cmd.eval, !cmd.wr_alloc && !cmd.wr_clear,
                   "two memory writes at once")
endmodule

// ===== rtl/core/tftp_read_session_table.sv =====
// Top level of the TFTP read session table.
// Usage:
//   in_ch  : one packet item per handshake (opcode, client key, ack, time,
//            file lookup result). Accepted when valid and ready are high.
//   out_ch : zero or one data-block descriptor per item.
//   cfg_we/cfg_wdata : write reuse_timeout_ms; write only while idle.
// Search: a read request walks the slot table once for its key search and,
// when the file is found, once more for the session search; an
// acknowledgement walks it only for the session search. The walk goes one
// slot a cycle through the single slot memory port and ends early when a
// key matches; a new item is accepted only after the last one is finished.
// Reset: synchronous, clears the controller, the round robin pointer and the
// per-slot valid bits at once, so every slot reads as zero; no sweep.
// Stall: a result waits in the output register until taken; no new item is
// accepted until then.
// Depends on trst_pkg, trst_if, trst_ctrl, trst_datapath, trst_ram.
module tftp_read_session_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  trst_in_if.sink     in_ch,
  trst_out_if.source  out_ch
);
  trst_pkg::cmd_t  cmd;
  trst_pkg::stat_t stat;

  trst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .stat(stat)
  );

  trst_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .stat(stat), .in_ch(in_ch),
    .r_slot(out_ch.slot_index), .r_addr(out_ch.dst_addr), .r_port(out_ch.dst_port),
    .r_block(out_ch.data_block), .r_offset(out_ch.read_offset),
    .r_len(out_ch.payload_len), .r_final(out_ch.is_final)
  );
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for tftp_read_session_table: random and directed packet items,
// with results predicted by a behavioral model of the session table.
// Depends on trst_pkg, trst_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] ack_block;
    logic [31:0] now_ms;
    logic        file_found;
    logic [31:0] file_size;
  } pkt_t;

  typedef struct packed {
    logic [trst_pkg::SlotW-1:0] slot_index;
    logic [31:0]      dst_addr;
    logic [15:0]      dst_port;
    logic [15:0]      data_block;
    logic [24:0]      read_offset;
    logic [9:0]       payload_len;
    logic             is_final;
  } blk_t;

  localparam int DrainCycles = 300;
  localparam int IdleLimit   = 5000;
  localparam int NumKeys     = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  trst_in_if  in_ch ();
  trst_out_if out_ch ();

  tftp_read_session_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the session table
  logic [31:0] tbl_addr [trst_pkg::NumSlots];
  logic [15:0] tbl_port [trst_pkg::NumSlots];
  logic [15:0] tbl_block [trst_pkg::NumSlots];
  logic        tbl_dropped [trst_pkg::NumSlots];
  logic [31:0] tbl_last [trst_pkg::NumSlots];
  logic [31:0] tbl_fsize [trst_pkg::NumSlots];
  int          rr_ptr;
  logic [31:0] timeout_ms;

  pkt_t pending_pkts[$];
  blk_t expected_blks[$];
  int   mismatches = 0;
  int   served = 0;
  int   accepted = 0;
  int   idle_cycles = 0;

  // Generator state: client keys and the block each client should acknowledge next
  logic [31:0] key_addr [NumKeys];
  logic [15:0] key_port [NumKeys];
  logic [15:0] key_next [NumKeys];
  logic [31:0] clock_ms = 32'd0;

  function automatic int lookup_slot(logic [31:0] a, logic [15:0] p);
    for (int k = 0; k < trst_pkg::NumSlots; k++)
      if (tbl_addr[k] == a && tbl_port[k] == p) return k;
    return trst_pkg::NumSlots;
  endfunction

  // Apply one packet to the shadow table; return 1 when a data block goes out
  function automatic bit serve_packet(pkt_t p, output blk_t b);
    int s;
    logic [15:0] ack;
    logic [31:0] off, len;
    b = '0;
    ack = p.ack_block;
    if (p.opcode != trst_pkg::OpRrq && p.opcode != trst_pkg::OpAck) return 0;
    if (p.opcode == trst_pkg::OpRrq) begin
      s = lookup_slot(p.src_addr, p.src_port);
      if (s < trst_pkg::NumSlots && (p.now_ms - tbl_last[s]) > timeout_ms) begin
        tbl_addr[s] = '0;
        tbl_dropped[s] = 1'b0;
        s = trst_pkg::NumSlots;
      end
      if (s >= trst_pkg::NumSlots) begin
        s = rr_ptr;
        rr_ptr = (rr_ptr + 1 >= trst_pkg::NumSlots) ? 0 : rr_ptr + 1;
      end
      if (!p.file_found) return 0;
      tbl_dropped[s] = 1'b0;
      tbl_block[s] = '0;
      tbl_addr[s] = p.src_addr;
      tbl_port[s] = p.src_port;
      tbl_fsize[s] = p.file_size;
      ack = '0;
    end
    s = lookup_slot(p.src_addr, p.src_port);
    if (s >= trst_pkg::NumSlots) return 0;
    if (tbl_block[s] != ack) begin
      if (!tbl_dropped[s]) begin
        tbl_dropped[s] = 1'b1;
        return 0;
      end
      tbl_block[s] = ack;
    end
    tbl_dropped[s] = 1'b0;
    off = {7'd0, tbl_block[s], 9'd0};
    if (off > tbl_fsize[s]) return 0;
    len = tbl_fsize[s] - off;
    if (len > trst_pkg::BlockBytes) len = trst_pkg::BlockBytes;
    tbl_block[s] = tbl_block[s] + 16'd1;
    tbl_last[s] = p.now_ms;
    b.slot_index  = s[trst_pkg::SlotW-1:0];
    b.dst_addr    = p.src_addr;
    b.dst_port    = p.src_port;
    b.data_block  = tbl_block[s];
    b.read_offset = off[24:0];
    b.payload_len = len[9:0];
    b.is_final    = (len < trst_pkg::BlockBytes);
    return 1;
  endfunction

  function automatic pkt_t make_pkt(logic [1:0] op, int key, logic [15:0] ack,
                                    logic found, logic [31:0] fsize);
    pkt_t p;
    p.opcode = op;
    p.src_addr = key_addr[key];
    p.src_port = key_port[key];
    p.ack_block = ack;
    p.now_ms = clock_ms;
    p.file_found = found;
    p.file_size = fsize;
    return p;
  endfunction

  function automatic pkt_t in_ch_pkt();
    pkt_t p;
    p.opcode = in_ch.opcode;
    p.src_addr = in_ch.src_addr;
    p.src_port = in_ch.src_port;
    p.ack_block = in_ch.ack_block;
    p.now_ms = in_ch.now_ms;
    p.file_found = in_ch.file_found;
    p.file_size = in_ch.file_size;
    return p;
  endfunction

  // Advance the millisecond clock, mostly in small steps
  task automatic tick_clock();
    if ($urandom_range(0, 19) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 400);
  endtask

  task automatic gen_random(int n);
    int k;
    pkt_t p;
    logic [31:0] fsize;
    for (int i = 0; i < n; i++) begin
      tick_clock();
      k = $urandom_range(0, NumKeys - 1);
      // Fresh random client now and then, so the round robin pointer walks the table
      if ($urandom_range(0, 3) == 0) begin
        key_addr[k] = $urandom;
        key_port[k] = 16'($urandom);
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          fsize = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000);
          p = make_pkt(trst_pkg::OpRrq, k, 16'($urandom), $urandom_range(0, 7) != 0, fsize);
          if (p.file_found) key_next[k] = 16'd1;
        end
        2: begin
          p = make_pkt(trst_pkg::OpAck, k, 16'($urandom), 1'($urandom), $urandom);
        end
        3: begin
          p = make_pkt(2'($urandom_range(2, 3)), k, 16'($urandom), 1'($urandom), $urandom);
          p.src_addr = $urandom;
        end
        default: begin
          p = make_pkt(trst_pkg::OpAck, k, key_next[k], 1'($urandom), $urandom);
          key_next[k] = key_next[k] + 16'd1;
        end
      endcase
      pending_pkts.push_back(p);
    end
  endtask

  task automatic gen_directed();
    pkt_t p;
    // Zero key matches slot 0 after reset: empty final block
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 0, 16'd0, 1'b0, 32'd0));
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 1, 16'd0, 1'b0, 32'd0)); // unknown
    pending_pkts.push_back(make_pkt(trst_pkg::OpRrq, 1, 16'hFFFF, 1'b0, 32'd100)); // no file
    pending_pkts.push_back(make_pkt(trst_pkg::OpRrq, 1, 16'd0, 1'b1, 32'd512));
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 1, 16'd1, 1'b0, 32'd0)); // empty final
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 1, 16'd2, 1'b0, 32'd0)); // past end
    pending_pkts.push_back(make_pkt(trst_pkg::OpRrq, 2, 16'd0, 1'b1, 32'hFFFF_FFFF));
    // Two mismatched acks adopt the block; the top block wraps the counter
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 2, 16'hFFFF, 1'b1, 32'd0));
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 2, 16'hFFFF, 1'b1, 32'd0));
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 2, 16'd0, 1'b0, 32'd0));
    pending_pkts.push_back(make_pkt(2'd2, 2, 16'd1, 1'b1, 32'hFFFF_FFFF));
    pending_pkts.push_back(make_pkt(2'd3, 2, 16'd1, 1'b1, 32'hFFFF_FFFF));
    pending_pkts.push_back(make_pkt(trst_pkg::OpRrq, 3, 16'd0, 1'b1, 32'd0));
    // Request again after a long idle stretch takes a fresh slot
    clock_ms = clock_ms + 32'd6000;
    pending_pkts.push_back(make_pkt(trst_pkg::OpRrq, 1, 16'd0, 1'b1, 32'd1000));
    p = make_pkt(trst_pkg::OpAck, 1, 16'd1, 1'b0, 32'd0);
    pending_pkts.push_back(p);
    clock_ms = 32'hFFFF_FFF0;
    pending_pkts.push_back(make_pkt(trst_pkg::OpRrq, 1, 16'd0, 1'b1, 32'd700));
    clock_ms = 32'd5;
    pending_pkts.push_back(make_pkt(trst_pkg::OpAck, 1, 16'd1, 1'b0, 32'd0));
  endtask

  // Sender: bursts of items with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    blk_t b;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted++;
        if (serve_packet(in_ch_pkt(), b)) expected_blks.push_back(b);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_pkts.size() > 0) begin
          pkt_t p;
          p = pending_pkts.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= p.opcode;
          in_ch.src_addr   <= p.src_addr;
          in_ch.src_port   <= p.src_port;
          in_ch.ack_block  <= p.ack_block;
          in_ch.now_ms     <= p.now_ms;
          in_ch.file_found <= p.file_found;
          in_ch.file_size  <= p.file_size;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern with long stretches of steady ready
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Compare each data block with the oldest prediction
  always @(posedge clk) begin
    blk_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.slot_index, out_ch.dst_addr, out_ch.dst_port, out_ch.data_block,
             out_ch.read_offset, out_ch.payload_len, out_ch.is_final};
      served++;
      if (expected_blks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected block: %p", got);
      end else begin
        want = expected_blks.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL tftp_read_session_table");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_pkts.size() > 0 || in_ch.valid || expected_blks.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    timeout_ms = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] settings [5];
    for (int k = 0; k < trst_pkg::NumSlots; k++) begin
      tbl_addr[k] = '0;
      tbl_port[k] = '0;
      tbl_block[k] = '0;
      tbl_dropped[k] = 1'b0;
      tbl_last[k] = '0;
      tbl_fsize[k] = '0;
    end
    rr_ptr = 0;
    timeout_ms = trst_pkg::TimeoutReset;
    for (int k = 0; k < NumKeys; k++) begin
      key_addr[k] = (k == 0) ? 32'd0 : $urandom;
      key_port[k] = (k == 0) ? 16'd0 : 16'($urandom);
      key_next[k] = 16'd0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the timeout first
    gen_directed();
    wait_idle();

    settings[0] = 32'd0;
    settings[1] = 32'hFFFF_FFFF;
    settings[2] = 32'd5000;
    settings[3] = $urandom_range(0, 2000);
    settings[4] = $urandom;
    foreach (settings[i]) begin
      write_timeout(settings[i]);
      gen_random(100);
      wait_idle();
    end

    $display("covered %0d packet items, %0d data blocks, six timeout settings",
             accepted, served);
    if (mismatches == 0) begin
      $display("PASS tftp_read_session_table");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL tftp_read_session_table");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/trst_pkg.sv
rtl/core/trst_if.sv
rtl/core/trst_ram.sv
rtl/core/trst_datapath.sv
rtl/core/trst_ctrl.sv
rtl/core/tftp_read_session_table.sv
tb/tb_top.sv
